### hdl/isotrn_pkg.sv
// Shared types, constants and helper functions of the ISO 8583 trace number extractor.
package isotrn_pkg;

    // Parse phases of one message
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_BITMAP = 3'd1,
        PH_LEN    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    // One input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_item;

    // Result of one parse step
    typedef struct packed {
        logic        valid;
        logic [19:0] trace_number;
    } t_result;

    // Outcome of the search for the next present field
    typedef struct packed {
        logic       found;
        logic [3:0] idx;
    } t_find;

    localparam int unsigned ADDR_W = 3;
    localparam logic        REG_HEADER_LENGTH = 1'b0;
    localparam logic [7:0]  HEADER_LEN_RESET  = 8'd4;
    localparam logic [7:0]  BITMAP_BYTES      = 8'd8;
    localparam logic [7:0]  LEN_DIGITS        = 8'd2;
    localparam logic [2:0]  TRACE_DIGITS      = 3'd6;
    localparam logic [3:0]  FIRST_FIELD       = 4'd1;
    localparam logic [3:0]  LAST_FIELD        = 4'd10;
    localparam logic [3:0]  LLVAR_FIELD       = 4'd2;
    localparam logic [3:0]  TRACE_FIELD       = 4'd11;
    localparam logic [7:0]  ASCII_ZERO        = 8'h30;
    localparam logic [7:0]  ASCII_NINE        = 8'h39;

    // Fixed byte length of each field before the trace number
    function automatic logic [6:0] field_skip_len(input logic [3:0] idx);
        logic [6:0] len;
        case (idx)
            4'd1:    len = 7'd8;
            4'd3:    len = 7'd6;
            4'd4:    len = 7'd12;
            4'd5:    len = 7'd12;
            4'd6:    len = 7'd12;
            4'd7:    len = 7'd10;
            4'd8:    len = 7'd8;
            4'd9:    len = 7'd8;
            4'd10:   len = 7'd8;
            default: len = 7'd0;
        endcase
        return len;
    endfunction

    // Lowest present field at or above start, up to field 10; bit 15 of the bitmap is field 1
    function automatic t_find find_field(input logic [15:0] bm, input logic [3:0] start);
        t_find f;
        f.found = 1'b0;
        f.idx   = TRACE_FIELD;
        for (int i = 10; i >= 1; i--) begin
            if (4'(i) >= start && bm[16 - i]) begin
                f.found = 1'b1;
                f.idx   = 4'(i);
            end
        end
        return f;
    endfunction

endpackage

### hdl/isotrn_parser.sv
// Per-byte parse state and its update on each processed byte.
module isotrn_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  isotrn_pkg::t_item   i_item,
    input  logic [7:0]          i_header_length,
    output isotrn_pkg::t_result o_result
);
    import isotrn_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_count,  n_count;
    logic [15:0] r_bitmap, n_bitmap;
    logic [3:0]  r_field,  n_field;
    logic [6:0]  r_skip,   n_skip;
    logic [6:0]  r_len,    n_len;
    logic [2:0]  r_pos,    n_pos;
    logic [19:0] r_trace,  n_trace;
    logic        r_ended,  n_ended;

    logic        is_digit;
    logic [3:0]  digit;
    logic [3:0]  adv_start;
    logic        do_adv;
    t_find       adv;
    logic [9:0]  len_x10;
    logic [23:0] trace_x10;

    assign is_digit = (i_item.data_byte >= ASCII_ZERO) && (i_item.data_byte <= ASCII_NINE);
    assign digit    = 4'(i_item.data_byte - ASCII_ZERO);

    // Compute the state after one byte
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_bitmap = r_bitmap;
        n_field  = r_field;
        n_skip   = r_skip;
        n_len    = r_len;
        n_pos    = r_pos;
        n_trace  = r_trace;
        n_ended  = r_ended;
        do_adv   = 1'b0;
        o_result = '0;

        // Restart on the first byte of a message
        if (i_item.first_byte) begin
            n_phase  = PH_HEADER;
            n_count  = '0;
            n_bitmap = '0;
            n_field  = FIRST_FIELD;
            n_skip   = '0;
            n_len    = '0;
            n_pos    = '0;
            n_trace  = '0;
            n_ended  = 1'b0;
        end

        // Leave the header once enough bytes are counted
        if (n_phase == PH_HEADER && n_count >= i_header_length) begin
            n_phase = PH_BITMAP;
            n_count = '0;
        end

        adv_start = (n_phase == PH_BITMAP) ? FIRST_FIELD : n_field + 4'd1;
        adv       = find_field(n_bitmap, adv_start);
        len_x10   = {n_len, 3'b000} + {2'b00, n_len, 1'b0};
        trace_x10 = {1'b0, n_trace, 3'b000} + {3'b000, n_trace, 1'b0};

        case (n_phase)
            PH_HEADER: begin
                n_count = n_count + 8'd1;
            end
            PH_BITMAP: begin
                if (n_count == 8'd0) begin
                    n_bitmap[15:8] = i_item.data_byte;
                end else if (n_count == 8'd1) begin
                    n_bitmap[7:0] = i_item.data_byte;
                end
                n_count = n_count + 8'd1;
                if (n_count >= BITMAP_BYTES) begin
                    do_adv = 1'b1;
                end
            end
            PH_LEN: begin
                if (!n_ended && is_digit) begin
                    n_len = 7'(len_x10 + {6'd0, digit});
                end else begin
                    n_ended = 1'b1;
                end
                n_count = n_count + 8'd1;
                if (n_count >= LEN_DIGITS) begin
                    n_ended = 1'b0;
                    if (n_len == 7'd0) begin
                        do_adv = 1'b1;
                    end else begin
                        n_phase = PH_SKIP;
                        n_skip  = n_len;
                    end
                end
            end
            PH_SKIP: begin
                if (n_skip != 7'd0) begin
                    n_skip = n_skip - 7'd1;
                end
                if (n_skip == 7'd0) begin
                    do_adv = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (!n_ended && is_digit) begin
                    n_trace = 20'(trace_x10 + {20'd0, digit});
                end else begin
                    n_ended = 1'b1;
                end
                n_pos = n_pos + 3'd1;
                if (n_pos >= TRACE_DIGITS) begin
                    n_phase               = PH_DONE;
                    o_result.valid        = i_step;
                    o_result.trace_number = n_trace;
                end
            end
            default: begin
            end
        endcase

        // Move on to the next present field, or to the trace digits
        if (do_adv) begin
            n_field = adv.idx;
            if (adv.found) begin
                if (adv.idx == LLVAR_FIELD) begin
                    n_phase = PH_LEN;
                    n_count = '0;
                    n_len   = '0;
                    n_ended = 1'b0;
                end else begin
                    n_phase = PH_SKIP;
                    n_skip  = field_skip_len(adv.idx);
                end
            end else begin
                n_phase = PH_DIGITS;
                n_pos   = '0;
                n_trace = '0;
                n_ended = 1'b0;
            end
        end
    end

    // Advance the parse state on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_count  <= '0;
            r_bitmap <= '0;
            r_field  <= FIRST_FIELD;
            r_skip   <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_trace  <= '0;
            r_ended  <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_bitmap <= n_bitmap;
            r_field  <= n_field;
            r_skip   <= n_skip;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_trace  <= n_trace;
            r_ended  <= n_ended;
        end
    end

endmodule

### hdl/iso8583_trace_number_extractor.sv
// Top level: input register, parser, result register and register port.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  input   | in        | i_in_valid / o_in_stall    | i_data_byte, i_first_byte
//  result  | out       | o_out_valid / i_out_stall  | o_trace_number
//  config  | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One item per cycle unless a held result stalls: an accepted item is held in the
// input register, and the parser updates its state from it and loads the result
// register, so the sixth trace byte passes the input register, then its result the result register.
// Reset (synchronous, active low) clears the parse state, the valid flags and
// sets header_length to 4. A stall on a held result keeps the result register
// and, once the input register is full, stalls the input side.
module iso8583_trace_number_extractor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_first_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [19:0]                   o_trace_number,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [isotrn_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import isotrn_pkg::*;

    logic        r_in_valid;
    t_item       r_in_item;
    logic        r_out_valid;
    logic [19:0] r_out_trace;
    logic [7:0]  r_header_length;
    logic        move;
    logic        step;
    logic        reg_sel;
    t_result     result;

    // Advance the pipeline unless a held result blocks it
    assign move       = !(r_out_valid && i_out_stall);
    assign step       = r_in_valid && move;
    assign o_in_stall = r_in_valid && !move;

    // Capture input items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item.data_byte  <= i_data_byte;
            r_in_item.first_byte <= i_first_byte;
        end
    end

    isotrn_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_item          (r_in_item),
        .i_header_length (r_header_length),
        .o_result        (result)
    );

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move && result.valid) begin
            r_out_trace <= result.trace_number;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_trace_number = r_out_trace;

    // Register port: header_length at address 0
    assign reg_sel = (paddr[2] == REG_HEADER_LENGTH);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {24'd0, r_header_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length <= HEADER_LEN_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_header_length <= pwdata[7:0];
        end
    end

    // The input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // A new result comes only from a processed item
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a processed item");

    // Six decimal digits never exceed 999999
    a_trace_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_trace <= 20'd999999))
        else $error("trace number out of range");

endmodule

### dv/iso8583_trace_number_extractor_tb.sv
// Self-checking testbench for the ISO 8583 trace number extractor.
module iso8583_trace_number_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isotrn_pkg::*;

    localparam int TARGET_ITEMS   = 1350;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_TAIL     = 6;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} t_idle_mode;

    // One message byte waiting to be offered, with an optional pause for results
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       drain;
    } t_msg_byte;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_first_byte   = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0] pwdata         = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [19:0] o_trace_number;
    logic [31:0] prdata;
    logic        pready;

    iso8583_trace_number_extractor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_trace_number (o_trace_number),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    t_msg_byte   msg_bytes[$];
    logic [19:0] trace_due[$];
    int          items_sent   = 0;
    int          errors       = 0;
    t_idle_mode  send_mode    = IDLE_NONE;
    t_idle_mode  recv_mode    = IDLE_NONE;
    int          hold_asked   = 0;
    logic        in_took      = 1'b0;
    logic        out_took     = 1'b0;

    // Parser state tracked alongside the block
    logic [7:0]  hdr_len;
    t_phase      ps_phase;
    logic [7:0]  ps_count;
    logic [15:0] ps_bitmap;
    logic [3:0]  ps_field;
    logic [6:0]  ps_skip;
    logic [6:0]  ps_len;
    logic [2:0]  ps_digit;
    logic [19:0] ps_value;
    logic        ps_ended;

    function automatic logic is_ascii_digit(input logic [7:0] c);
        return c >= ASCII_ZERO && c <= ASCII_NINE;
    endfunction

    // Byte length of each fixed field ahead of the trace number
    function automatic int fixed_field_len(input int field);
        case (field)
            1, 8, 9, 10: return 8;
            3:           return 6;
            4, 5, 6:     return 12;
            7:           return 10;
            default:     return 0;
        endcase
    endfunction

    function automatic void restart_message();
        ps_phase  = PH_HEADER;
        ps_count  = '0;
        ps_bitmap = '0;
        ps_field  = FIRST_FIELD;
        ps_skip   = '0;
        ps_len    = '0;
        ps_digit  = '0;
        ps_value  = '0;
        ps_ended  = 1'b0;
    endfunction

    // Move to the next present field, or on to the trace digits
    function automatic void next_present_field();
        while (ps_field >= FIRST_FIELD && ps_field <= LAST_FIELD) begin
            if (ps_bitmap[16 - int'(ps_field)]) begin
                if (ps_field == LLVAR_FIELD) begin
                    ps_phase = PH_LEN;
                    ps_count = '0;
                    ps_len   = '0;
                    ps_ended = 1'b0;
                end else begin
                    ps_phase = PH_SKIP;
                    ps_skip  = 7'(fixed_field_len(int'(ps_field)));
                end
                return;
            end
            ps_field = ps_field + 4'd1;
        end
        ps_field = TRACE_FIELD;
        ps_phase = PH_DIGITS;
        ps_digit = '0;
        ps_value = '0;
        ps_ended = 1'b0;
    endfunction

    // Advance the parse by one byte; flag a trace number after its sixth digit
    function automatic void parse_byte(input logic [7:0] b, input logic first,
                                       output logic hit, output logic [19:0] value);
        hit   = 1'b0;
        value = '0;
        if (first)
            restart_message();
        if (ps_phase == PH_HEADER && ps_count >= hdr_len) begin
            ps_phase = PH_BITMAP;
            ps_count = '0;
        end
        case (ps_phase)
            PH_HEADER: ps_count = ps_count + 8'd1;
            PH_BITMAP: begin
                if (ps_count == 8'd0)
                    ps_bitmap[15:8] = b;
                else if (ps_count == 8'd1)
                    ps_bitmap[7:0] = b;
                ps_count = ps_count + 8'd1;
                if (ps_count >= BITMAP_BYTES) begin
                    ps_field = FIRST_FIELD;
                    next_present_field();
                end
            end
            PH_LEN: begin
                if (!ps_ended && is_ascii_digit(b))
                    ps_len = 7'(int'(ps_len) * 10 + int'(b - ASCII_ZERO));
                else
                    ps_ended = 1'b1;
                ps_count = ps_count + 8'd1;
                if (ps_count >= LEN_DIGITS) begin
                    ps_ended = 1'b0;
                    if (ps_len == '0) begin
                        ps_field = ps_field + 4'd1;
                        next_present_field();
                    end else begin
                        ps_phase = PH_SKIP;
                        ps_skip  = ps_len;
                    end
                end
            end
            PH_SKIP: begin
                if (ps_skip > 0)
                    ps_skip = ps_skip - 7'd1;
                if (ps_skip == '0) begin
                    ps_field = ps_field + 4'd1;
                    next_present_field();
                end
            end
            PH_DIGITS: begin
                if (!ps_ended && is_ascii_digit(b))
                    ps_value = 20'(int'(ps_value) * 10 + int'(b - ASCII_ZERO));
                else
                    ps_ended = 1'b1;
                ps_digit = ps_digit + 3'd1;
                if (ps_digit >= TRACE_DIGITS) begin
                    ps_phase = PH_DONE;
                    hit      = 1'b1;
                    value    = ps_value;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int draw_wait(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_HEAVY: return $urandom_range(0, 14);
            default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        endcase
    endfunction

    function automatic logic [7:0] random_non_digit();
        logic [7:0] c;
        do c = 8'($urandom); while (is_ascii_digit(c));
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic first, input logic drain);
        t_msg_byte m;
        m.data  = b;
        m.first = first;
        m.drain = drain;
        msg_bytes.push_back(m);
        items_sent++;
    endtask

    // Build one message: header, bitmap, present fields, trace digits, trailing bytes.
    // cut > 0 truncates it; drain_ctl 0 never, 1 sometimes, 2 always pauses first.
    task automatic queue_message(input int hdr_bytes, input logic restart, input int cut,
                                 input int drain_ctl);
        logic [7:0]  body[$];
        logic [15:0] bm;
        logic        drain;
        int          mode, len, bad_pos, total;
        case ($urandom_range(0, 9))
            0:       bm = '0;
            1:       bm = '1;
            2:       bm = 16'($urandom);
            default: bm = 16'($urandom & $urandom & $urandom);
        endcase
        repeat (hdr_bytes) body.push_back(8'($urandom));
        body.push_back(bm[15:8]);
        body.push_back(bm[7:0]);
        repeat (6) body.push_back(8'($urandom));
        for (int f = 1; f <= int'(LAST_FIELD); f++) begin
            if (!bm[16 - f])
                continue;
            if (f == int'(LLVAR_FIELD)) begin
                mode = $urandom_range(0, 9);
                if (mode == 0) begin
                    // non-digit first: length is zero
                    body.push_back(random_non_digit());
                    body.push_back(8'($urandom));
                end else if (mode == 1) begin
                    // non-digit second: one-digit length
                    len = $urandom_range(0, 9);
                    body.push_back(8'(ASCII_ZERO + len));
                    body.push_back(random_non_digit());
                    repeat (len) body.push_back(8'($urandom));
                end else begin
                    len = (mode == 2) ? 0 : (mode == 3) ? $urandom_range(0, 99)
                                                        : $urandom_range(1, 12);
                    body.push_back(8'(ASCII_ZERO + len / 10));
                    body.push_back(8'(ASCII_ZERO + len % 10));
                    repeat (len) body.push_back(8'($urandom));
                end
            end else begin
                repeat (fixed_field_len(f)) body.push_back(8'($urandom));
            end
        end
        // Trace digits, sometimes with a sign, a space or a stray non-digit
        mode    = $urandom_range(0, 7);
        bad_pos = $urandom_range(0, 5);
        for (int p = 0; p < int'(TRACE_DIGITS); p++) begin
            case (mode)
                0: begin
                    if (p == 0) begin
                        case ($urandom_range(0, 2))
                            0:       body.push_back(ASCII_SPACE);
                            1:       body.push_back(ASCII_PLUS);
                            default: body.push_back(ASCII_MINUS);
                        endcase
                    end else begin
                        body.push_back(8'(ASCII_ZERO + $urandom_range(0, 9)));
                    end
                end
                1: body.push_back(p == bad_pos ? random_non_digit()
                                               : 8'(ASCII_ZERO + $urandom_range(0, 9)));
                2: body.push_back(ASCII_NINE);
                3: body.push_back(ASCII_ZERO);
                default: body.push_back(8'(ASCII_ZERO + $urandom_range(0, 9)));
            endcase
        end
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
        total = (cut > 0 && cut < body.size()) ? cut : body.size();
        drain = (drain_ctl == 2) || (drain_ctl == 1 && $urandom_range(0, 11) == 0);
        for (int i = 0; i < total; i++)
            push_byte(body[i], restart && i == 0, drain && i == 0);
    endtask

    // Wait until every byte is taken and every trace number has arrived
    task automatic wait_all_done();
        do @(negedge i_clk);
        while (msg_bytes.size() != 0 || i_in_valid || trace_due.size() != 0);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    task automatic write_header_length(input logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * REG_HEADER_LENGTH);
        pwdata  <= {24'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        hdr_len = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer message bytes; hold the payload until the item is taken
    int gap_left = 0;
    always @(negedge i_clk) begin : feed_bytes
        t_msg_byte nxt;
        logic      send_valid;
        send_valid = i_in_valid;
        if (i_rst_n) begin
            if (in_took)
                send_valid = 1'b0;
            if (!send_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (msg_bytes.size() != 0 &&
                             !(msg_bytes[0].drain && trace_due.size() != 0)) begin
                    nxt = msg_bytes.pop_front();
                    i_data_byte  <= nxt.data;
                    i_first_byte <= nxt.first;
                    send_valid = 1'b1;
                    gap_left   = draw_wait(send_mode);
                end
            end
        end
        i_in_valid <= send_valid;
    end

    // Stall the result side: per-item waits, plus one long hold on request
    int hold_served = 0;
    int hold_left   = 0;
    int out_wait    = 0;
    always @(negedge i_clk) begin : pace_results
        logic stall_now;
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
        end
        if (out_took)
            out_wait = draw_wait(recv_mode);
        if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
        end else if (o_out_valid === 1'b1 && out_wait > 0) begin
            out_wait--;
            stall_now = 1'b1;
        end else begin
            stall_now = 1'b0;
        end
        i_out_stall <= stall_now;
    end

    // Check results, track accepted bytes, and watch for a hang
    int idle_cycles = 0;
    always @(posedge i_clk) begin : watch_ports
        logic        hit;
        logic [19:0] value;
        logic [19:0] want;
        logic        in_acc, out_acc, cfg_acc;
        in_acc  = i_rst_n && i_in_valid && o_in_stall === 1'b0;
        out_acc = i_rst_n && o_out_valid === 1'b1 && !i_out_stall;
        cfg_acc = psel && penable && pwrite && pready === 1'b1;
        in_took  <= in_acc;
        out_took <= out_acc;
        if (out_acc) begin
            if (trace_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected trace number, expected none, got %0d",
                         $time, o_trace_number);
            end else begin
                want = trace_due.pop_front();
                if (o_trace_number !== want) begin
                    errors++;
                    $display("%0t: trace number mismatch, expected %0d, got %0d",
                             $time, want, o_trace_number);
                end
            end
        end
        if (in_acc) begin
            parse_byte(i_data_byte, i_first_byte, hit, value);
            if (hit)
                trace_due.push_back(value);
        end
        if (!i_rst_n || in_acc || out_acc || cfg_acc)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL iso8583_trace_number_extractor");
            $finish;
        end
    end

    // Stimulus
    initial begin : run_messages
        int hl, carry, phase, nmsg, k;
        hdr_len = HEADER_LEN_RESET;
        restart_message();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No first-byte flag, reset header length, empty bitmap, largest trace
        send_mode = IDLE_LIGHT;
        recv_mode = IDLE_LIGHT;
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        repeat (6) push_byte(8'($urandom), 1'b0, 1'b0);
        repeat (6) push_byte(ASCII_NINE, 1'b0, 1'b0);
        wait_all_done();

        // No header, zero-length field 2, leading space, then an ignored byte
        write_header_length(8'd0);
        @(posedge i_clk);
        push_byte(8'h40, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        repeat (6) push_byte(8'($urandom), 1'b0, 1'b0);
        push_byte(ASCII_ZERO, 1'b0, 1'b0);
        push_byte(ASCII_ZERO, 1'b0, 1'b0);
        push_byte(ASCII_SPACE, 1'b0, 1'b0);
        for (int d = 1; d <= 5; d++)
            push_byte(8'(ASCII_ZERO + d), 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);

        // Random phases, each with its own header length and idling
        carry = -1;
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            wait_all_done();
            case (phase)
                0: hl = 255;
                1: hl = 0;
                2: hl = 1;
                default: begin
                    k = $urandom_range(0, 19);
                    hl = (k == 0) ? 255 : (k == 1) ? $urandom_range(9, 255)
                                                   : $urandom_range(0, 8);
                end
            endcase
            write_header_length(8'(hl));
            @(posedge i_clk);
            send_mode = t_idle_mode'($urandom_range(0, 2));
            recv_mode = t_idle_mode'($urandom_range(0, 2));
            // Finish a message left mid-header under the new length
            if (carry >= 0)
                queue_message(hl > carry ? hl - carry : 0, 1'b0, 0, 1);
            carry = -1;
            nmsg  = (hl > 16) ? 1 : $urandom_range(3, 8);
            if (phase == 2) begin
                // Hold results off while bytes keep coming, so the block backs up
                send_mode = IDLE_NONE;
                recv_mode = IDLE_NONE;
                hold_asked++;
                repeat (8) queue_message(hl, 1'b1, 0, 0);
            end else begin
                for (int m = 0; m < nmsg; m++) begin
                    k = $urandom_range(0, 15);
                    if (k == 0) begin
                        repeat ($urandom_range(5, 30))
                            push_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0);
                    end else if (k <= 2) begin
                        queue_message(hl, 1'b1, $urandom_range(1, 40), 1);
                    end else begin
                        queue_message(hl, 1'b1, 0, (phase == 3 && m == 0) ? 2 : 1);
                    end
                end
            end
            // Sometimes stop partway through a header before the next length change
            if (hl >= 2 && hl <= 16 && $urandom_range(0, 2) == 0) begin
                carry = $urandom_range(1, hl - 1);
                push_byte(8'($urandom), 1'b1, 1'b0);
                repeat (carry - 1) push_byte(8'($urandom), 1'b0, 1'b0);
            end
            phase++;
        end
        wait_all_done();

        if (errors == 0 && trace_due.size() == 0) begin
            $display("PASS iso8583_trace_number_extractor");
        end else begin
            $display("FAIL iso8583_trace_number_extractor");
        end
        $finish;
    end

endmodule
